/* sv/bli_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Battery level blink indicator package
// Shared types, register codes, reset values and the flash count rounding.
// ----------------------------------------------------------------------------
package bli_pkg;

  // Operation codes of an input item.
  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_UPDATE = 2'd1,
    OP_PRESS  = 2'd2
  } op_e;

  // Blink sequence phases.
  typedef enum logic [2:0] {
    PH_LEFT_ON   = 3'd0,
    PH_LEFT_OFF  = 3'd1,
    PH_GAP       = 3'd2,
    PH_RIGHT_ON  = 3'd3,
    PH_RIGHT_OFF = 3'd4,
    PH_DONE      = 3'd5
  } phase_e;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_ON_TIME   = 3'd0,
    REG_OFF_TIME  = 3'd1,
    REG_SIDE_GAP  = 3'd2,
    REG_THRESHOLD = 3'd3,
    REG_LEFT_ID   = 3'd4,
    REG_RIGHT_ID  = 3'd5
  } reg_idx_e;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned TimeW    = 16;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned FlashW   = 4;

  localparam logic [TimeW-1:0] OnTimeRst    = 16'd250;
  localparam logic [TimeW-1:0] OffTimeRst   = 16'd200;
  localparam logic [TimeW-1:0] SideGapRst   = 16'd600;
  localparam logic [ByteW-1:0] ThresholdRst = 8'd34;
  localparam logic [ByteW-1:0] LeftIdRst    = 8'd0;
  localparam logic [ByteW-1:0] RightIdRst   = 8'd1;

  // Rounding offset and reciprocal of ten (205 / 2048, exact below 1029).
  localparam logic [8:0]  RoundOfs  = 9'd5;
  localparam logic [16:0] RecipTen  = 17'd205;

  // Configuration register set.
  typedef struct packed {
    logic [TimeW-1:0] on_time;
    logic [TimeW-1:0] off_time;
    logic [TimeW-1:0] side_gap;
    logic [ByteW-1:0] threshold;
    logic [ByteW-1:0] left_id;
    logic [ByteW-1:0] right_id;
  } cfg_t;

  // One result item.
  typedef struct packed {
    logic left_on;
    logic right_on;
    logic busy;
  } res_t;

  // Charge percent divided by ten, rounded to nearest; at most 26.
  function automatic logic [4:0] div10_round(input logic [ByteW-1:0] pct);
    logic [8:0]  biased;
    logic [16:0] prod;
    biased = {1'b0, pct} + RoundOfs;
    prod   = 17'(biased) * RecipTen;
    return prod[15:11];
  endfunction

endpackage

/* sv/bli_seq.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Battery level blink sequencer
// Holds the charge levels, pins and blink state, and resolves one item per
// cycle while enabled, collapsing any run of zero-delay phases in that cycle.
// ----------------------------------------------------------------------------
module bli_seq #(
  parameter int unsigned TIMER_BITS  = 16,
  parameter int unsigned MAX_FLASHES = 10
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic [1:0]                   op_i,
  input  logic [bli_pkg::ByteW-1:0]    source_i,
  input  logic [bli_pkg::ByteW-1:0]    charge_i,
  input  bli_pkg::cfg_t                cfg_i,
  output bli_pkg::res_t                res_o
);

  logic [bli_pkg::ByteW-1:0]  left_level_q, left_level_d;
  logic [bli_pkg::ByteW-1:0]  right_level_q, right_level_d;
  logic                       running_q, running_d;
  bli_pkg::phase_e            phase_q, phase_d;
  logic [bli_pkg::FlashW-1:0] flashes_q, flashes_d;
  logic [TIMER_BITS-1:0]      wait_q, wait_d;
  logic                       left_pin_q, left_pin_d;
  logic                       right_pin_q, right_pin_d;

  // Clamp a delay register into the timer width.
  function automatic logic [TIMER_BITS-1:0] sat_delay(input logic [bli_pkg::TimeW-1:0] v);
    logic [31:0] wide;
    logic [31:0] lim;
    wide = 32'(v);
    lim  = 32'((33'd1 << TIMER_BITS) - 33'd1);
    if (wide > lim) begin
      return TIMER_BITS'(lim);
    end
    return TIMER_BITS'(wide);
  endfunction

  // Number of flashes for a charge level, held to one through MAX_FLASHES.
  function automatic logic [bli_pkg::FlashW-1:0] flash_count(
      input logic [bli_pkg::ByteW-1:0] pct);
    logic [4:0] n;
    n = bli_pkg::div10_round(pct);
    if (n > 5'(MAX_FLASHES)) begin
      return bli_pkg::FlashW'(MAX_FLASHES);
    end
    if (n == 5'd0) begin
      return bli_pkg::FlashW'(1);
    end
    return n[bli_pkg::FlashW-1:0];
  endfunction

  logic [bli_pkg::FlashW-1:0] left_count, right_count;
  logic                       left_low, right_low;

  assign left_count  = flash_count(left_level_q);
  assign right_count = flash_count(right_level_q);
  assign left_low    = (left_level_q < cfg_i.threshold);
  assign right_low   = (right_level_q < cfg_i.threshold);

  // Next state: handle the item, then run phases until one sets a delay.
  always_comb begin
    logic                       go;
    logic [bli_pkg::FlashW-1:0] fdec;
    left_level_d  = left_level_q;
    right_level_d = right_level_q;
    running_d     = running_q;
    phase_d       = phase_q;
    flashes_d     = flashes_q;
    wait_d        = wait_q;
    left_pin_d    = left_pin_q;
    right_pin_d   = right_pin_q;
    go            = 1'b0;
    fdec          = '0;

    case (bli_pkg::op_e'(op_i))
      bli_pkg::OP_TICK: begin
        if (running_q) begin
          wait_d = (wait_q != '0) ? wait_q - TIMER_BITS'(1) : '0;
          go     = (wait_d == '0);
        end
      end
      bli_pkg::OP_UPDATE: begin
        if (source_i == cfg_i.left_id) begin
          left_level_d = charge_i;
          if (!running_q) begin
            left_pin_d = (charge_i < cfg_i.threshold);
          end
        end else if (source_i == cfg_i.right_id) begin
          right_level_d = charge_i;
          if (!running_q) begin
            right_pin_d = (charge_i < cfg_i.threshold);
          end
        end
      end
      bli_pkg::OP_PRESS: begin
        if (!running_q) begin
          running_d = 1'b1;
          phase_d   = bli_pkg::PH_LEFT_ON;
          flashes_d = left_count;
          go        = 1'b1;
        end
      end
      default: begin
      end
    endcase

    // Left flash lights.
    if (go && phase_d == bli_pkg::PH_LEFT_ON) begin
      left_pin_d = 1'b1;
      phase_d    = bli_pkg::PH_LEFT_OFF;
      if (cfg_i.on_time != '0) begin
        wait_d = sat_delay(cfg_i.on_time);
        go     = 1'b0;
      end
    end

    // Left flash ends; with both times zero the remaining flashes collapse.
    if (go && phase_d == bli_pkg::PH_LEFT_OFF) begin
      left_pin_d = 1'b0;
      fdec       = (flashes_d != '0) ? flashes_d - bli_pkg::FlashW'(1) : '0;
      if (fdec != '0 && cfg_i.off_time != '0) begin
        phase_d   = bli_pkg::PH_LEFT_ON;
        flashes_d = fdec;
        wait_d    = sat_delay(cfg_i.off_time);
        go        = 1'b0;
      end else if (fdec != '0 && cfg_i.on_time != '0) begin
        left_pin_d = 1'b1;
        phase_d    = bli_pkg::PH_LEFT_OFF;
        flashes_d  = fdec;
        wait_d     = sat_delay(cfg_i.on_time);
        go         = 1'b0;
      end else begin
        flashes_d = '0;
        phase_d   = bli_pkg::PH_GAP;
        if (cfg_i.side_gap != '0) begin
          wait_d = sat_delay(cfg_i.side_gap);
          go     = 1'b0;
        end
      end
    end

    // Gap over: load the right flash count.
    if (go && phase_d == bli_pkg::PH_GAP) begin
      flashes_d = right_count;
      phase_d   = bli_pkg::PH_RIGHT_ON;
    end

    // Right flash lights.
    if (go && phase_d == bli_pkg::PH_RIGHT_ON) begin
      right_pin_d = 1'b1;
      phase_d     = bli_pkg::PH_RIGHT_OFF;
      if (cfg_i.on_time != '0) begin
        wait_d = sat_delay(cfg_i.on_time);
        go     = 1'b0;
      end
    end

    // Right flash ends.
    if (go && phase_d == bli_pkg::PH_RIGHT_OFF) begin
      right_pin_d = 1'b0;
      fdec        = (flashes_d != '0) ? flashes_d - bli_pkg::FlashW'(1) : '0;
      if (fdec != '0 && cfg_i.off_time != '0) begin
        phase_d   = bli_pkg::PH_RIGHT_ON;
        flashes_d = fdec;
        wait_d    = sat_delay(cfg_i.off_time);
        go        = 1'b0;
      end else if (fdec != '0 && cfg_i.on_time != '0) begin
        right_pin_d = 1'b1;
        phase_d     = bli_pkg::PH_RIGHT_OFF;
        flashes_d   = fdec;
        wait_d      = sat_delay(cfg_i.on_time);
        go          = 1'b0;
      end else begin
        flashes_d = '0;
        phase_d   = bli_pkg::PH_DONE;
      end
    end

    // Sequence finished, or an unused phase code: restore the idle rule.
    if (go) begin
      left_pin_d  = left_low;
      right_pin_d = right_low;
      running_d   = 1'b0;
      wait_d      = '0;
    end
  end

  // State registers, updated only when an item is taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_level_q  <= '0;
      right_level_q <= '0;
      running_q     <= 1'b0;
      phase_q       <= bli_pkg::PH_LEFT_ON;
      flashes_q     <= '0;
      wait_q        <= '0;
      left_pin_q    <= 1'b0;
      right_pin_q   <= 1'b0;
    end else if (en_i) begin
      left_level_q  <= left_level_d;
      right_level_q <= right_level_d;
      running_q     <= running_d;
      phase_q       <= phase_d;
      flashes_q     <= flashes_d;
      wait_q        <= wait_d;
      left_pin_q    <= left_pin_d;
      right_pin_q   <= right_pin_d;
    end
  end

  // Result of the item being handled.
  always_comb begin
    res_o.left_on  = left_pin_d;
    res_o.right_on = right_pin_d;
    res_o.busy     = running_d;
  end

endmodule

/* sv/battery_level_blink_indicator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Battery level blink indicator
// Two battery LEDs with an idle low-charge rule and a press-started blink
// readout of the left and right charge levels.
// ----------------------------------------------------------------------------
// The block takes one item (tick, charge update or press) every clock cycle
// while input ready is high, and returns one result item for each: the pin
// levels and busy flag after that item. A result enters the output queue as
// its item is taken. All work for an item is done in the single sequencer
// stage, including any run of phases whose delay is zero. Results wait in a
// two-entry output queue, so input can keep flowing while the output stalls;
// input ready drops only while both entries are full. Configuration registers
// are written through a plain write port and take effect on the next item.
module battery_level_blink_indicator #(
  parameter int unsigned TIMER_BITS  = 16,
  parameter int unsigned MAX_FLASHES = 10
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    op_i,
  input  logic [bli_pkg::ByteW-1:0]     source_i,
  input  logic [bli_pkg::ByteW-1:0]     charge_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          left_led_o,
  output logic                          right_led_o,
  output logic                          busy_res_o,
  input  logic                          cfg_we_i,
  input  logic [bli_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [bli_pkg::CfgDataW-1:0]  cfg_data_i
);

  bli_pkg::cfg_t cfg_q;
  bli_pkg::res_t res;
  bli_pkg::res_t slot0_q, slot1_q;
  logic [1:0]    count_q;
  logic          push, pop;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.on_time   <= bli_pkg::OnTimeRst;
      cfg_q.off_time  <= bli_pkg::OffTimeRst;
      cfg_q.side_gap  <= bli_pkg::SideGapRst;
      cfg_q.threshold <= bli_pkg::ThresholdRst;
      cfg_q.left_id   <= bli_pkg::LeftIdRst;
      cfg_q.right_id  <= bli_pkg::RightIdRst;
    end else if (cfg_we_i) begin
      case (bli_pkg::reg_idx_e'(cfg_index_i))
        bli_pkg::REG_ON_TIME:   cfg_q.on_time   <= cfg_data_i;
        bli_pkg::REG_OFF_TIME:  cfg_q.off_time  <= cfg_data_i;
        bli_pkg::REG_SIDE_GAP:  cfg_q.side_gap  <= cfg_data_i;
        bli_pkg::REG_THRESHOLD: cfg_q.threshold <= cfg_data_i[bli_pkg::ByteW-1:0];
        bli_pkg::REG_LEFT_ID:   cfg_q.left_id   <= cfg_data_i[bli_pkg::ByteW-1:0];
        bli_pkg::REG_RIGHT_ID:  cfg_q.right_id  <= cfg_data_i[bli_pkg::ByteW-1:0];
        default: begin
        end
      endcase
    end
  end

  // Handshakes.
  assign in_ready_o = (count_q != 2'd2);
  assign push       = in_valid_i && in_ready_o;
  assign pop        = (count_q != 2'd0) && out_ready_i;

  bli_seq #(
    .TIMER_BITS  (TIMER_BITS),
    .MAX_FLASHES (MAX_FLASHES)
  ) u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (push),
    .op_i     (op_i),
    .source_i (source_i),
    .charge_i (charge_i),
    .cfg_i    (cfg_q),
    .res_o    (res)
  );

  // Two-entry output queue; slot 0 is the head.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 2'd0;
    end else if (push && !pop) begin
      count_q <= count_q + 2'd1;
    end else if (pop && !push) begin
      count_q <= count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push && !pop) begin
      if (count_q == 2'd0) begin
        slot0_q <= res;
      end else begin
        slot1_q <= res;
      end
    end else if (pop && !push) begin
      slot0_q <= slot1_q;
    end else if (pop && push) begin
      if (count_q == 2'd1) begin
        slot0_q <= res;
      end else begin
        slot0_q <= slot1_q;
        slot1_q <= res;
      end
    end
  end

  // Output ports.
  assign out_valid_o = (count_q != 2'd0);
  assign left_led_o  = slot0_q.left_on;
  assign right_led_o = slot0_q.right_on;
  assign busy_res_o  = slot0_q.busy;

endmodule
